/* rtl/assert_macros.svh */
// Assertion macros shared by the complex arithmetic unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define CAU_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("%m: same-cycle implication failed");

// Next-cycle implication, checked at every rising clock edge out of reset.
`define CAU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: next-cycle implication failed");

`endif

/* rtl/cau_pkg.sv */
`timescale 1ns / 1ps

package cau_pkg;

  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned FRAC_BITS  = 16;

  localparam int unsigned PW = 2 * DATA_WIDTH;
  localparam int unsigned SW = PW + 1;
  localparam int unsigned QB = DATA_WIDTH + 1;
  localparam int unsigned MW = PW + FRAC_BITS;

  typedef enum logic [1:0] {
    OpAdd = 2'd0,
    OpSub = 2'd1,
    OpMul = 2'd2,
    OpDiv = 2'd3
  } action_e;

  typedef struct packed {
    logic [PW:0]   rem;
    logic [QB-1:0] low;
    logic [QB-1:0] quo;
  } lane_t;

  typedef struct packed {
    action_e               op;
    logic                  dz;
    logic                  neg_re;
    logic                  neg_im;
    logic                  big_re;
    logic                  big_im;
    logic [DATA_WIDTH-1:0] fix_re;
    logic [DATA_WIDTH-1:0] fix_im;
    logic                  fix_ov;
  } side_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] val;
    logic                  ov;
  } sat_t;

  localparam logic [DATA_WIDTH-1:0] MaxVal = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] MinVal = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic signed [SW-1:0] SatMax = {{(SW-DATA_WIDTH+1){1'b0}},
                                             {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [SW-1:0] SatMin = {{(SW-DATA_WIDTH+1){1'b1}},
                                             {(DATA_WIDTH-1){1'b0}}};
  localparam logic [QB-1:0] LimPos = {2'b00, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [QB-1:0] LimNeg = {2'b01, {(DATA_WIDTH-1){1'b0}}};
  localparam logic signed [SW-1:0] RoundBias = SW'((65'd1 << FRAC_BITS) - 65'd1);

  function automatic sat_t saturate(logic signed [SW-1:0] v);
    sat_t r;
    r.ov  = 1'b1;
    r.val = v[DATA_WIDTH-1:0];
    if (v > SatMax) begin
      r.val = MaxVal;
    end else if (v < SatMin) begin
      r.val = MinVal;
    end else begin
      r.ov = 1'b0;
    end
    return r;
  endfunction

  function automatic lane_t div_step(lane_t l, logic [PW-1:0] den);
    logic [PW:0] r2;
    logic        ge;
    lane_t       o;
    r2    = {l.rem[PW-1:0], l.low[QB-1]};
    ge    = (r2 >= {1'b0, den});
    o.rem = ge ? (r2 - {1'b0, den}) : r2;
    o.low = {l.low[QB-2:0], 1'b0};
    o.quo = {l.quo[QB-2:0], ge};
    return o;
  endfunction

  function automatic sat_t div_finish(logic [QB-1:0] q, logic neg, logic big);
    sat_t          r;
    logic [QB-1:0] nq;
    nq = ~q + QB'(1);
    if (neg) begin
      r.ov  = big || (q > LimNeg);
      r.val = r.ov ? MinVal : nq[DATA_WIDTH-1:0];
    end else begin
      r.ov  = big || (q > LimPos);
      r.val = r.ov ? MaxVal : q[DATA_WIDTH-1:0];
    end
    return r;
  endfunction

endpackage

/* rtl/cau_front.sv */
`timescale 1ns / 1ps

module cau_front import cau_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  action_e                      op_i,
  input  logic signed [DATA_WIDTH-1:0] a_re_i,
  input  logic signed [DATA_WIDTH-1:0] a_im_i,
  input  logic signed [DATA_WIDTH-1:0] b_re_i,
  input  logic signed [DATA_WIDTH-1:0] b_im_i,
  output logic                         valid_o,
  output logic [PW-1:0]                den_o,
  output lane_t                        lane_re_o,
  output lane_t                        lane_im_o,
  output side_t                        side_o
);

  logic                       v1_q, v2_q, v3_q;
  action_e                    op1_q, op2_q;
  logic signed [PW-1:0]       p_rr_q, p_ii_q, p_ri_q, p_ir_q, p_dr_q, p_di_q;
  logic signed [DATA_WIDTH:0] s_re_q, s_im_q, s_re2_q, s_im2_q;
  logic signed [SW-1:0]       t_re_q, t_im_q;
  logic [PW-1:0]              den2_q, den3_q;
  lane_t                      lre_q, lim_q;
  side_t                      side_q;

  logic signed [DATA_WIDTH:0] s_re_d, s_im_d;
  logic signed [SW-1:0]       t_re_d, t_im_d;
  logic [PW-1:0]              den2_d;
  lane_t                      lre_d, lim_d;
  side_t                      side_d;

  always_comb begin
    if (op_i == OpSub) begin
      s_re_d = (DATA_WIDTH+1)'(a_re_i) - (DATA_WIDTH+1)'(b_re_i);
      s_im_d = (DATA_WIDTH+1)'(a_im_i) - (DATA_WIDTH+1)'(b_im_i);
    end else begin
      s_re_d = (DATA_WIDTH+1)'(a_re_i) + (DATA_WIDTH+1)'(b_re_i);
      s_im_d = (DATA_WIDTH+1)'(a_im_i) + (DATA_WIDTH+1)'(b_im_i);
    end
  end

  always_comb begin
    den2_d = PW'(p_dr_q) + PW'(p_di_q);
    if (op1_q == OpDiv) begin
      t_re_d = SW'(p_rr_q) + SW'(p_ii_q);
      t_im_d = SW'(p_ir_q) - SW'(p_ri_q);
    end else begin
      t_re_d = SW'(p_rr_q) - SW'(p_ii_q);
      t_im_d = SW'(p_ri_q) + SW'(p_ir_q);
    end
  end

  function automatic lane_t lane_init(logic signed [SW-1:0] t, logic [PW-1:0] den,
                                      output logic neg, output logic big);
    logic [SW-1:0] mag;
    logic [MW-1:0] m;
    lane_t         l;
    neg   = t[SW-1];
    mag   = neg ? (~t + SW'(1)) : t;
    m     = MW'(mag[PW-1:0]) << FRAC_BITS;
    big   = ((MW+QB)'(m) >= ((MW+QB)'(den) << QB));
    l.rem = (PW+1)'(m >> QB);
    l.low = m[QB-1:0];
    l.quo = '0;
    return l;
  endfunction

  always_comb begin
    logic signed [SW-1:0] sc_re, sc_im;
    sat_t                 f_re, f_im;
    sc_re = $signed(t_re_q + (t_re_q[SW-1] ? RoundBias : '0)) >>> FRAC_BITS;
    sc_im = $signed(t_im_q + (t_im_q[SW-1] ? RoundBias : '0)) >>> FRAC_BITS;
    if (op2_q == OpMul) begin
      f_re = saturate(sc_re);
      f_im = saturate(sc_im);
    end else begin
      f_re = saturate(SW'(s_re2_q));
      f_im = saturate(SW'(s_im2_q));
    end
    lre_d         = lane_init(t_re_q, den2_q, side_d.neg_re, side_d.big_re);
    lim_d         = lane_init(t_im_q, den2_q, side_d.neg_im, side_d.big_im);
    side_d.op     = op2_q;
    side_d.dz     = (op2_q == OpDiv) && (den2_q == '0);
    side_d.fix_re = f_re.val;
    side_d.fix_im = f_im.val;
    side_d.fix_ov = f_re.ov || f_im.ov;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    op1_q   <= op_i;
    p_rr_q  <= PW'(a_re_i) * PW'(b_re_i);
    p_ii_q  <= PW'(a_im_i) * PW'(b_im_i);
    p_ri_q  <= PW'(a_re_i) * PW'(b_im_i);
    p_ir_q  <= PW'(a_im_i) * PW'(b_re_i);
    p_dr_q  <= PW'(b_re_i) * PW'(b_re_i);
    p_di_q  <= PW'(b_im_i) * PW'(b_im_i);
    s_re_q  <= s_re_d;
    s_im_q  <= s_im_d;
    op2_q   <= op1_q;
    t_re_q  <= t_re_d;
    t_im_q  <= t_im_d;
    den2_q  <= den2_d;
    s_re2_q <= s_re_q;
    s_im2_q <= s_im_q;
    den3_q  <= den2_q;
    lre_q   <= lre_d;
    lim_q   <= lim_d;
    side_q  <= side_d;
  end

  assign valid_o   = v3_q;
  assign den_o     = den3_q;
  assign lane_re_o = lre_q;
  assign lane_im_o = lim_q;
  assign side_o    = side_q;

endmodule

/* rtl/cau_div.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cau_div import cau_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [PW-1:0] den_i,
  input  lane_t         lane_re_i,
  input  lane_t         lane_im_i,
  input  side_t         side_i,
  output logic          valid_o,
  output lane_t         lane_re_o,
  output lane_t         lane_im_o,
  output side_t         side_o
);

  logic          valid_q [QB];
  logic [PW-1:0] den_q   [QB];
  lane_t         lre_q   [QB];
  lane_t         lim_q   [QB];
  side_t         side_q  [QB];

  logic          v_src    [QB];
  logic [PW-1:0] den_src  [QB];
  lane_t         lre_src  [QB];
  lane_t         lim_src  [QB];
  side_t         side_src [QB];

  assign v_src[0]    = valid_i;
  assign den_src[0]  = den_i;
  assign lre_src[0]  = lane_re_i;
  assign lim_src[0]  = lane_im_i;
  assign side_src[0] = side_i;

  for (genvar i = 0; i < QB; i++) begin : g_step
    if (i > 0) begin : g_link
      assign v_src[i]    = valid_q[i-1];
      assign den_src[i]  = den_q[i-1];
      assign lre_src[i]  = lre_q[i-1];
      assign lim_src[i]  = lim_q[i-1];
      assign side_src[i] = side_q[i-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[i] <= 1'b0;
      end else begin
        valid_q[i] <= v_src[i];
      end
    end

    always_ff @(posedge clk_i) begin
      den_q[i]  <= den_src[i];
      lre_q[i]  <= div_step(lre_src[i], den_src[i]);
      lim_q[i]  <= div_step(lim_src[i], den_src[i]);
      side_q[i] <= side_src[i];
    end
  end

  assign valid_o   = valid_q[QB-1];
  assign lane_re_o = lre_q[QB-1];
  assign lane_im_o = lim_q[QB-1];
  assign side_o    = side_q[QB-1];

  `CAU_ASSERT_NEXT(a_first_step_moves, clk_i, rst_ni, valid_q[0], valid_q[1])

endmodule

/* rtl/complex_arithmetic_unit.sv */
// Complex arithmetic unit: add, subtract, multiply and divide on signed fixed-point pairs.
// The done strobe follows a taken item through the front registers, the quotient stages and the output register.
// Throughput: one item per cycle; busy never rises, as the receiver cannot stall results.
// Depth is set by the quotient pipeline, one quotient bit per stage for both parts.
// Reset is asynchronous and active low; it clears all valid bits, no clearing pass is needed.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module complex_arithmetic_unit import cau_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [1:0]                   action_i,
  input  logic signed [DATA_WIDTH-1:0] a_re_i,
  input  logic signed [DATA_WIDTH-1:0] a_im_i,
  input  logic signed [DATA_WIDTH-1:0] b_re_i,
  input  logic signed [DATA_WIDTH-1:0] b_im_i,
  output logic                         done_o,
  output logic signed [DATA_WIDTH-1:0] res_re_o,
  output logic signed [DATA_WIDTH-1:0] res_im_o,
  output logic                         div_by_zero_o,
  output logic                         overflow_o
);

  logic          f_valid, d_valid;
  logic [PW-1:0] f_den;
  lane_t         f_lre, f_lim, d_lre, d_lim;
  side_t         f_side, d_side;

  logic                  done_q, dz_q, ov_q;
  logic [DATA_WIDTH-1:0] re_q, im_q;
  logic [DATA_WIDTH-1:0] re_d, im_d;
  logic                  dz_d, ov_d;

  assign busy_o = 1'b0;

  cau_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (start_i && !busy_o),
    .op_i      (action_e'(action_i)),
    .a_re_i    (a_re_i),
    .a_im_i    (a_im_i),
    .b_re_i    (b_re_i),
    .b_im_i    (b_im_i),
    .valid_o   (f_valid),
    .den_o     (f_den),
    .lane_re_o (f_lre),
    .lane_im_o (f_lim),
    .side_o    (f_side)
  );

  cau_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (f_valid),
    .den_i     (f_den),
    .lane_re_i (f_lre),
    .lane_im_i (f_lim),
    .side_i    (f_side),
    .valid_o   (d_valid),
    .lane_re_o (d_lre),
    .lane_im_o (d_lim),
    .side_o    (d_side)
  );

  always_comb begin
    sat_t q_re, q_im;
    q_re = div_finish(d_lre.quo, d_side.neg_re, d_side.big_re);
    q_im = div_finish(d_lim.quo, d_side.neg_im, d_side.big_im);
    dz_d = 1'b0;
    if (d_side.op != OpDiv) begin
      re_d = d_side.fix_re;
      im_d = d_side.fix_im;
      ov_d = d_side.fix_ov;
    end else if (d_side.dz) begin
      re_d = '0;
      im_d = '0;
      ov_d = 1'b0;
      dz_d = 1'b1;
    end else begin
      re_d = q_re.val;
      im_d = q_im.val;
      ov_d = q_re.ov || q_im.ov;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
      dz_q   <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      done_q <= d_valid;
      dz_q   <= d_valid && dz_d;
      ov_q   <= d_valid && ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    re_q <= re_d;
    im_q <= im_d;
  end

  assign done_o        = done_q;
  assign res_re_o      = re_q;
  assign res_im_o      = im_q;
  assign div_by_zero_o = dz_q;
  assign overflow_o    = ov_q;

  `CAU_ASSERT_IMPL(a_dz_gives_zero, clk_i, rst_ni, div_by_zero_o, res_re_o == '0 && res_im_o == '0 && !overflow_o)
  `CAU_ASSERT_IMPL(a_ov_is_limit, clk_i, rst_ni, overflow_o, res_re_o == MaxVal || res_re_o == MinVal || res_im_o == MaxVal || res_im_o == MinVal)
  `CAU_ASSERT_IMPL(a_flags_need_done, clk_i, rst_ni, !done_o, !div_by_zero_o && !overflow_o)

endmodule
